/* rtl/rvdec_pkg.sv */
package rvdec_pkg;

    // Major opcodes
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_OPIMMW = 7'h1B;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_OPW    = 7'h3B;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // funct3 codes used by the function checks, including the shift forms
    localparam logic [2:0] F3_ADD = 3'h0;
    localparam logic [2:0] F3_SLL = 3'h1;
    localparam logic [2:0] F3_SLT = 3'h2;
    localparam logic [2:0] F3_SLTU = 3'h3;
    localparam logic [2:0] F3_SRX = 3'h5;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // Upper six bits of a 64-bit immediate shift
    localparam logic [5:0] SHIFT_HI_BASE = 6'h00;
    localparam logic [5:0] SHIFT_HI_ALT  = 6'h10;

    // ALU operation kind, upper bits of alu_op
    localparam logic [1:0] KIND_BASE   = 2'd0;
    localparam logic [1:0] KIND_ALT    = 2'd1;
    localparam logic [1:0] KIND_MULDIV = 2'd2;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_OPCODE = 2'd1,
        FAULT_FUNC   = 2'd2
    } fault_t;

    typedef struct packed {
        logic [6:0]  major_opcode;
        logic [4:0]  dest_reg;
        logic [4:0]  src_reg_a;
        logic [4:0]  src_reg_b;
        logic [2:0]  func_three;
        logic [63:0] immediate;
        logic [4:0]  alu_op;
        fault_t      fault;
    } dec_result_t;

endpackage

/* rtl/rvdec_core.sv */
module rvdec_core (
    input  logic [31:0]              word,
    output rvdec_pkg::dec_result_t   result
);
    import rvdec_pkg::*;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [63:0] imm_i;
    logic [63:0] imm_s;
    logic [63:0] imm_b;
    logic [63:0] imm_u;
    logic [63:0] imm_j;
    logic [63:0] imm_sh;
    logic [63:0] imm_shw;
    logic [1:0]  kind;
    logic        ok;

    assign opc = word[6:0];
    assign f3  = word[14:12];
    assign f7  = word[31:25];

    // Immediate forms, sign extended to 64 bits; the shift amounts are zero extended
    assign imm_i   = {{52{word[31]}}, word[31:20]};
    assign imm_s   = {{52{word[31]}}, word[31:25], word[11:7]};
    assign imm_b   = {{51{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign imm_u   = {{32{word[31]}}, word[31:12], 12'b0};
    assign imm_j   = {{43{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
    assign imm_sh  = {58'b0, word[25:20]};
    assign imm_shw = {59'b0, word[24:20]};

    // Decode by major opcode
    always_comb
    begin
        result              = '0;
        result.major_opcode = opc;
        result.fault        = FAULT_NONE;
        kind                = KIND_BASE;
        ok                  = 1'b1;
        unique case (opc) inside
            OPC_OP, OPC_OPW:
            begin
                result.dest_reg   = word[11:7];
                result.func_three = f3;
                result.src_reg_a  = word[19:15];
                result.src_reg_b  = word[24:20];
                if (f7 == F7_BASE)
                begin
                    kind = KIND_BASE;
                    if (opc == OPC_OPW && !(f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SRX))
                        ok = 1'b0;
                end
                else if (f7 == F7_ALT)
                begin
                    kind = KIND_ALT;
                    if (!(f3 == F3_ADD || f3 == F3_SRX))
                        ok = 1'b0;
                end
                else if (f7 == F7_MULDIV)
                begin
                    kind = KIND_MULDIV;
                    if (opc == OPC_OPW && (f3 == F3_SLL || f3 == F3_SLT || f3 == F3_SLTU))
                        ok = 1'b0;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            OPC_OPIMM, OPC_OPIMMW:
            begin
                result.dest_reg   = word[11:7];
                result.func_three = f3;
                result.src_reg_a  = word[19:15];
                if (f3 == F3_SLL || f3 == F3_SRX)
                begin
                    if (opc == OPC_OPIMM)
                    begin
                        result.immediate = imm_sh;
                        if (word[31:26] == SHIFT_HI_BASE)
                            kind = KIND_BASE;
                        else if (word[31:26] == SHIFT_HI_ALT && f3 == F3_SRX)
                            kind = KIND_ALT;
                        else
                            ok = 1'b0;
                    end
                    else
                    begin
                        result.immediate = imm_shw;
                        if (f7 == F7_BASE)
                            kind = KIND_BASE;
                        else if (f7 == F7_ALT && f3 == F3_SRX)
                            kind = KIND_ALT;
                        else
                            ok = 1'b0;
                    end
                end
                else
                begin
                    result.immediate = imm_i;
                    if (opc == OPC_OPIMMW && f3 != F3_ADD)
                        ok = 1'b0;
                end
            end
            OPC_LOAD, OPC_JALR:
            begin
                result.dest_reg   = word[11:7];
                result.func_three = f3;
                result.src_reg_a  = word[19:15];
                result.immediate  = imm_i;
            end
            OPC_STORE:
            begin
                result.func_three = f3;
                result.src_reg_a  = word[19:15];
                result.src_reg_b  = word[24:20];
                result.immediate  = imm_s;
            end
            OPC_BRANCH:
            begin
                result.func_three = f3;
                result.src_reg_a  = word[19:15];
                result.src_reg_b  = word[24:20];
                result.immediate  = imm_b;
            end
            OPC_LUI, OPC_AUIPC:
            begin
                result.dest_reg  = word[11:7];
                result.immediate = imm_u;
            end
            OPC_JAL:
            begin
                result.dest_reg  = word[11:7];
                result.immediate = imm_j;
            end
            OPC_SYSTEM:
            begin
                result.immediate = '0;
            end
            default:
            begin
                result.fault = FAULT_OPCODE;
            end
        endcase

        // ALU code only for the arithmetic groups, cleared on a bad function code
        if (opc == OPC_OP || opc == OPC_OPW || opc == OPC_OPIMM || opc == OPC_OPIMMW)
        begin
            if (ok)
                result.alu_op = {kind, f3};
            else
                result.fault = FAULT_FUNC;
        end
    end

endmodule

/* rtl/rv64_instruction_decoder_unit.sv */
// Channel   | Handshake           | Payload
// ----------+---------------------+---------------------------------------------
// command   | start, busy         | instr_word
// result    | done (strobe)       | major_opcode, dest_reg, src_reg_a, src_reg_b,
//           |                     | func_three, immediate, alu_op, fault
//
// One instruction per cycle: busy stays low, so start may be high every cycle.
// Each transaction passes through the input register, one pass of the
// decode logic and the result register; done pulses for one cycle with the result.
// Reset clears the valid and done flags; payload registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module rv64_instruction_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] instr_word,
    output logic        done,
    output logic [6:0]  major_opcode,
    output logic [4:0]  dest_reg,
    output logic [4:0]  src_reg_a,
    output logic [4:0]  src_reg_b,
    output logic [2:0]  func_three,
    output logic [63:0] immediate,
    output logic [4:0]  alu_op,
    output logic [1:0]  fault
);
    import rvdec_pkg::*;

    logic        valid_reg;
    logic [31:0] instr_reg;
    logic        done_reg;
    dec_result_t result_next;
    dec_result_t result_reg;

    // Never hold off a command
    assign busy = 1'b0;

    // Capture the command transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            instr_reg <= instr_word;
    end

    rvdec_core u_core (
        .word   (instr_reg),
        .result (result_next)
    );

    // Register the decoded result and raise the strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg)
            result_reg <= result_next;
    end

    assign done         = done_reg;
    assign major_opcode = result_reg.major_opcode;
    assign dest_reg     = result_reg.dest_reg;
    assign src_reg_a    = result_reg.src_reg_a;
    assign src_reg_b    = result_reg.src_reg_b;
    assign func_three   = result_reg.func_three;
    assign immediate    = result_reg.immediate;
    assign alu_op       = result_reg.alu_op;
    assign fault        = result_reg.fault;

    // Every command transaction yields a result once it has passed the input and result registers
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("command transaction produced no result");

    // No result without a command
    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result strobe without a command");

    // An unknown opcode clears every field but the opcode and the fault
    a_opcode_fault: assert property (@(posedge clk) disable iff (!rst_n)
        done && fault == FAULT_OPCODE |-> dest_reg == '0 && src_reg_a == '0 &&
            src_reg_b == '0 && func_three == '0 && immediate == '0 && alu_op == '0)
        else $error("unknown opcode result carries decoded fields");

    // Any fault leaves the ALU code at zero
    a_fault_alu: assert property (@(posedge clk) disable iff (!rst_n)
        done && fault != FAULT_NONE |-> alu_op == '0)
        else $error("faulting result carries an ALU code");

endmodule

/* bench/decode_checker.sv */
`timescale 1ns / 1ps

module decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] instr_word,
    input  logic        done,
    input  logic [6:0]  major_opcode,
    input  logic [4:0]  dest_reg,
    input  logic [4:0]  src_reg_a,
    input  logic [4:0]  src_reg_b,
    input  logic [2:0]  func_three,
    input  logic [63:0] immediate,
    input  logic [4:0]  alu_op,
    input  logic [1:0]  fault,
    output int          mismatches,
    output int          in_flight
);
    import rvdec_pkg::*;

    dec_result_t expected_decodes[$];

    // Decode one instruction word the way the unit is meant to
    function automatic dec_result_t decode_word(input logic [31:0] w);
        dec_result_t r;
        logic [6:0]  opc;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [11:0] i12;
        logic [1:0]  kind;
        logic        legal;
        logic        arith;
        r     = '0;
        opc   = w[6:0];
        f7    = w[31:25];
        f3    = w[14:12];
        i12   = w[31:20];
        kind  = KIND_BASE;
        legal = 1'b1;
        arith = 1'b0;
        r.major_opcode = opc;
        r.fault        = FAULT_NONE;
        case (opc)
            OPC_OP, OPC_OPW:
            begin
                arith        = 1'b1;
                r.dest_reg   = w[11:7];
                r.func_three = f3;
                r.src_reg_a  = w[19:15];
                r.src_reg_b  = w[24:20];
                if (f7 == F7_BASE)
                begin
                    if (opc == OPC_OPW && !(f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SRX))
                        legal = 1'b0;
                end
                else if (f7 == F7_ALT)
                begin
                    kind = KIND_ALT;
                    if (!(f3 == F3_ADD || f3 == F3_SRX))
                        legal = 1'b0;
                end
                else if (f7 == F7_MULDIV)
                begin
                    kind = KIND_MULDIV;
                    if (opc == OPC_OPW && (f3 == F3_SLL || f3 == F3_SLT || f3 == F3_SLTU))
                        legal = 1'b0;
                end
                else
                    legal = 1'b0;
            end
            OPC_OPIMM, OPC_OPIMMW:
            begin
                arith        = 1'b1;
                r.dest_reg   = w[11:7];
                r.func_three = f3;
                r.src_reg_a  = w[19:15];
                if (f3 == F3_SLL || f3 == F3_SRX)
                begin
                    // shift amount only: 6 bits for the doubleword form, 5 for the word form
                    if (opc == OPC_OPIMM)
                    begin
                        r.immediate = {58'd0, i12[5:0]};
                        if (w[31:26] == SHIFT_HI_BASE)
                            kind = KIND_BASE;
                        else if (w[31:26] == SHIFT_HI_ALT && f3 == F3_SRX)
                            kind = KIND_ALT;
                        else
                            legal = 1'b0;
                    end
                    else
                    begin
                        r.immediate = {59'd0, i12[4:0]};
                        if (f7 == F7_BASE)
                            kind = KIND_BASE;
                        else if (f7 == F7_ALT && f3 == F3_SRX)
                            kind = KIND_ALT;
                        else
                            legal = 1'b0;
                    end
                end
                else
                begin
                    r.immediate = {{52{i12[11]}}, i12};
                    if (opc == OPC_OPIMMW && f3 != F3_ADD)
                        legal = 1'b0;
                end
            end
            OPC_LOAD, OPC_JALR:
            begin
                r.dest_reg   = w[11:7];
                r.func_three = f3;
                r.src_reg_a  = w[19:15];
                r.immediate  = {{52{i12[11]}}, i12};
            end
            OPC_STORE:
            begin
                r.func_three = f3;
                r.src_reg_a  = w[19:15];
                r.src_reg_b  = w[24:20];
                r.immediate  = {{52{w[31]}}, w[31:25], w[11:7]};
            end
            OPC_BRANCH:
            begin
                r.func_three = f3;
                r.src_reg_a  = w[19:15];
                r.src_reg_b  = w[24:20];
                r.immediate  = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
            OPC_LUI, OPC_AUIPC:
            begin
                r.dest_reg  = w[11:7];
                r.immediate = {{32{w[31]}}, w[31:12], 12'd0};
            end
            OPC_JAL:
            begin
                r.dest_reg  = w[11:7];
                r.immediate = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OPC_SYSTEM:
            begin
            end
            default:
                r.fault = FAULT_OPCODE;
        endcase
        if (arith)
        begin
            if (legal)
                r.alu_op = {kind, f3};
            else
                r.fault = FAULT_FUNC;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        mismatches = 0;
        in_flight  = 0;
    end

    // Retire results against the oldest prediction, then queue new transactions
    always @(posedge clk)
    begin
        dec_result_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (expected_decodes.size() == 0)
                begin
                    $display("%0t: result with no transaction outstanding", $time);
                    mismatches++;
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    check_field("major_opcode", 64'(want.major_opcode), 64'(major_opcode));
                    check_field("dest_reg", 64'(want.dest_reg), 64'(dest_reg));
                    check_field("src_reg_a", 64'(want.src_reg_a), 64'(src_reg_a));
                    check_field("src_reg_b", 64'(want.src_reg_b), 64'(src_reg_b));
                    check_field("func_three", 64'(want.func_three), 64'(func_three));
                    check_field("immediate", want.immediate, immediate);
                    check_field("alu_op", 64'(want.alu_op), 64'(alu_op));
                    check_field("fault", 64'(want.fault), 64'(fault));
                end
            end
            if (start && busy === 1'b0)
                expected_decodes.push_back(decode_word(instr_word));
            in_flight = expected_decodes.size();
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import rvdec_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 650;
    localparam int DRAIN_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] instr_word;
    logic        done;
    logic [6:0]  major_opcode;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic [2:0]  func_three;
    logic [63:0] immediate;
    logic [4:0]  alu_op;
    logic [1:0]  fault;
    int          mismatches;
    int          in_flight;
    int          quiet_cycles;
    int          idle_pct;

    logic [6:0] known_opcodes[12] = '{OPC_LOAD, OPC_OPIMM, OPC_AUIPC, OPC_OPIMMW, OPC_STORE,
                                      OPC_OP, OPC_LUI, OPC_OPW, OPC_BRANCH, OPC_JALR,
                                      OPC_JAL, OPC_SYSTEM};

    logic [31:0] corner_words[30] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0033, 32'h4000_0033, 32'h4000_1033,
        32'h0200_0033, 32'h0200_703B, 32'h0200_203B, 32'h0000_203B, 32'hFE00_0033,
        32'h03F0_1013, 32'h43F0_5013, 32'h43F0_1013, 32'h01F0_101B, 32'h41F0_501B,
        32'h0200_101B, 32'h0000_201B, 32'hFFF0_0013, 32'h7FF0_0013, 32'hFFFF_FFE3,
        32'h8000_0063, 32'hFFFF_FFEF, 32'h8000_0037, 32'hFFFF_F017, 32'hFE00_0FA3,
        32'hFFFF_FF73, 32'hFFF0_0003, 32'hFFFF_FFE7, 32'hFFFF_FFBB, 32'h0000_0013};

    rv64_instruction_decoder_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .instr_word   (instr_word),
        .done         (done),
        .major_opcode (major_opcode),
        .dest_reg     (dest_reg),
        .src_reg_a    (src_reg_a),
        .src_reg_b    (src_reg_b),
        .func_three   (func_three),
        .immediate    (immediate),
        .alu_op       (alu_op),
        .fault        (fault)
    );

    decode_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .instr_word   (instr_word),
        .done         (done),
        .major_opcode (major_opcode),
        .dest_reg     (dest_reg),
        .src_reg_a    (src_reg_a),
        .src_reg_b    (src_reg_b),
        .func_three   (func_three),
        .immediate    (immediate),
        .alu_op       (alu_op),
        .fault        (fault),
        .mismatches   (mismatches),
        .in_flight    (in_flight)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Abort when neither a transaction nor a result moves for too long
    initial quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Build a mostly well-formed word with random operands, biased toward the function checks
    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        logic [6:0]  opc;
        w = $urandom;
        if ($urandom_range(99) < 12)
            return w;
        opc = known_opcodes[$urandom_range(11)];
        w[6:0] = opc;
        if (opc == OPC_OP || opc == OPC_OPW || opc == OPC_OPIMMW)
        begin
            case ($urandom_range(3))
                0: w[31:25] = F7_BASE;
                1: w[31:25] = F7_ALT;
                2: w[31:25] = F7_MULDIV;
                default: ;
            endcase
        end
        else if (opc == OPC_OPIMM)
        begin
            case ($urandom_range(2))
                0: w[31:26] = SHIFT_HI_BASE;
                1: w[31:26] = SHIFT_HI_ALT;
                default: ;
            endcase
        end
        if ((opc == OPC_OPIMM || opc == OPC_OPIMMW) && $urandom_range(1) == 1)
            w[14:12] = $urandom_range(1) ? F3_SLL : F3_SRX;
        return w;
    endfunction

    // Hand one transaction to the unit, idling first at the current rate
    task automatic send_instr(input logic [31:0] w);
        logic taken;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        instr_word <= w;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (busy === 1'b0);
            @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        instr_word = '0;
        idle_pct   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner words back to back
        foreach (corner_words[i])
            send_instr(corner_words[i]);

        // Random words: light sender idling, then heavy, then none
        idle_pct = 9;
        repeat (PHASE_ITEMS) send_instr(random_instr());
        idle_pct = 73;
        repeat (PHASE_ITEMS) send_instr(random_instr());
        idle_pct = 0;
        repeat (PHASE_ITEMS) send_instr(random_instr());
        start <= 1'b0;

        // Drain outstanding results
        while (in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && in_flight == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
